// File: rtl/lru_key_tracker_unit_defines.svh
// Assertion macros used by the key tracker top level.
`ifndef LRU_KEY_TRACKER_UNIT_DEFINES_SVH
`define LRU_KEY_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define LKT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lru_key_tracker: assertion failed");
// Next-cycle implication, checked out of reset.
`define LKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lru_key_tracker: assertion failed");
`else
`define LKT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LKT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/lkt_pkg.sv
// Types and constants shared by the key tracker modules.
package lkt_pkg;

	localparam int SLOTS     = 16;
	localparam int KEY_W     = 32;
	localparam int RANK_W    = $clog2(SLOTS);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int CAP_RESET = 4;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [SLOTS-1:0]  slot_mask_t;

	// Outcome of one access, handed from the update logic to the top level.
	typedef struct packed {
		logic       hit;
		logic       evict;
		key_t       evict_key;
		count_t     next_held;
		slot_mask_t evict_mask;
		slot_mask_t fill_mask;
	} lkt_decision_t;

endpackage

// File: rtl/lru_key_tracker_unit.sv
// Top level of the fully associative key tracker with least-recently-used replacement.
//
// The block tracks up to sixteen 32-bit keys in recency order. Each access
// transaction on the access channel (access_valid, access_stall, access_key)
// looks the key up in all slots at once. A hit makes the key the newest; a miss
// inserts it as the newest, evicting the oldest key first if the store is at
// capacity. One result transaction per access leaves on the result channel
// (result_valid, result_stall) with was_hit, did_evict, evicted_key and the
// occupancy after the access. evicted_key reads zero when nothing was evicted.
//
// An accepted key is held in the input register; its lookup and update are
// combinational, and the result is registered in the result register.
// Throughput is one access per cycle while the receiver does not stall. If the
// receiver stalls, the result register holds and the input register fills;
// access_stall then rises until the result is taken.
//
// The capacity register is written through cfg_valid/cfg_data, always ready, and
// should change only while no access is in flight. If it drops below the current
// occupancy, each later access evicts at most one key until the count fits.
// Reset empties the store, clears both channel registers and loads capacity 4.
`include "lru_key_tracker_unit_defines.svh"

module lru_key_tracker_unit
	import lkt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         access_valid,
	output logic         access_stall,
	input  logic [31:0]  access_key,
	output logic         result_valid,
	input  logic         result_stall,
	output logic         was_hit,
	output logic         did_evict,
	output logic [31:0]  evicted_key,
	output logic [4:0]   occupancy,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [4:0]   cfg_data
);

	// Tracker state.
	key_t       [SLOTS-1:0] keys_q;
	slot_mask_t             valid_q;
	rank_t      [SLOTS-1:0] ranks_q;
	count_t                 held_q;
	count_t                 capacity_q;

	// Input stage.
	logic                   valid_s1;
	key_t                   key_s1;

	// Result register.
	logic                   out_valid_q;
	logic                   hit_q;
	logic                   evict_q;
	key_t                   evict_key_q;
	count_t                 occ_q;

	logic                   out_free;
	logic                   proc;
	logic                   accept;
	slot_mask_t             next_valid;
	rank_t      [SLOTS-1:0] next_ranks;
	lkt_decision_t          dec;

	// The input stage advances when the result register is empty or being drained.
	assign out_free     = !out_valid_q || !result_stall;
	assign proc         = valid_s1 && out_free;
	assign access_stall = valid_s1 && !out_free;
	assign accept       = access_valid && !access_stall;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= count_t'(CAP_RESET);
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= access_key;
		end
	end

	lkt_update u_update (
		.key        (key_s1),
		.keys       (keys_q),
		.valid      (valid_q),
		.ranks      (ranks_q),
		.held       (held_q),
		.capacity   (capacity_q),
		.next_valid (next_valid),
		.next_ranks (next_ranks),
		.dec        (dec)
	);

	// Valid marks, ranks and the count reset to empty; stored keys need no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ranks_q <= '0;
			held_q  <= '0;
		end else if (proc) begin
			valid_q <= next_valid;
			ranks_q <= next_ranks;
			held_q  <= dec.next_held;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (proc && dec.fill_mask[i]) begin
				keys_q[i] <= key_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			hit_q       <= dec.hit;
			evict_q     <= dec.evict;
			evict_key_q <= dec.evict_key;
			occ_q       <= dec.next_held;
		end
	end

	assign result_valid = out_valid_q;
	assign was_hit      = hit_q;
	assign did_evict    = evict_q;
	assign evicted_key  = evict_key_q;
	assign occupancy    = occ_q;

	// The occupancy count must always agree with the number of valid slots.
	`LKT_ASSERT_IMPLY(a_count_matches, clk, arst_n, 1'b1, $countones(valid_q) == held_q)
	// At most one slot is chosen for eviction in any access.
	`LKT_ASSERT_IMPLY(a_one_evict, clk, arst_n, proc, $onehot0(dec.evict_mask))
	// A miss always finds exactly one slot to fill.
	`LKT_ASSERT_IMPLY(a_miss_fills, clk, arst_n, proc && !dec.hit, $onehot(dec.fill_mask))
	// After any access the store holds at least one key.
	`LKT_ASSERT_NEXT(a_nonempty, clk, arst_n, proc, valid_q != '0)

endmodule

// File: rtl/lkt_update.sv
// Lookup, recency update, eviction and slot allocation for one access.
module lkt_update
	import lkt_pkg::*;
(
	input  key_t                   key,
	input  key_t       [SLOTS-1:0] keys,
	input  slot_mask_t             valid,
	input  rank_t      [SLOTS-1:0] ranks,
	input  count_t                 held,
	input  count_t                 capacity,
	output slot_mask_t             next_valid,
	output rank_t      [SLOTS-1:0] next_ranks,
	output lkt_decision_t          dec
);

	count_t                 cap;
	slot_mask_t             match;
	rank_t                  hit_rank;
	count_t                 held_m1;
	rank_t                  lru_rank;
	rank_t      [SLOTS-1:0] promo;
	rank_t      [SLOTS-1:0] cand;
	slot_mask_t             kept;
	slot_mask_t             free;

	// A capacity of zero behaves as one; anything above the slot count saturates.
	always_comb begin
		if (capacity == '0) begin
			cap = count_t'(1);
		end else if (capacity > count_t'(SLOTS)) begin
			cap = count_t'(SLOTS);
		end else begin
			cap = capacity;
		end
	end

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = valid[i] && (keys[i] == key);
		end

		hit_rank = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (match[i]) begin
				hit_rank = hit_rank | ranks[i];
			end
		end

		held_m1  = held - count_t'(1);
		lru_rank = held_m1[RANK_W-1:0];

		// On a hit, every newer key ages by one and the hit key becomes newest.
		for (int i = 0; i < SLOTS; i++) begin
			if (match[i]) begin
				promo[i] = '0;
			end else if (valid[i] && (ranks[i] < hit_rank)) begin
				promo[i] = ranks[i] + rank_t'(1);
			end else begin
				promo[i] = ranks[i];
			end
		end

		dec.hit = |match;
		if (dec.hit) begin
			cand      = promo;
			dec.evict = held > cap;
		end else begin
			cand      = ranks;
			dec.evict = (held >= cap) && (held != '0);
		end

		for (int i = 0; i < SLOTS; i++) begin
			dec.evict_mask[i] = dec.evict && valid[i] && (cand[i] == lru_rank);
		end

		kept = valid & ~dec.evict_mask;
		free = ~kept;
		// A miss fills the lowest free slot, which may be the one just evicted.
		dec.fill_mask = dec.hit ? '0 : (free & (~free + slot_mask_t'(1)));

		dec.evict_key = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (dec.evict_mask[i]) begin
				dec.evict_key = dec.evict_key | keys[i];
			end
		end

		for (int i = 0; i < SLOTS; i++) begin
			next_valid[i] = kept[i] | dec.fill_mask[i];
			if (!kept[i]) begin
				next_ranks[i] = '0;
			end else if (dec.hit) begin
				next_ranks[i] = promo[i];
			end else begin
				next_ranks[i] = ranks[i] + rank_t'(1);
			end
		end

		dec.next_held = held - count_t'(dec.evict) + count_t'(|dec.fill_mask);
	end

endmodule
